>>> rtl/core/tdln_pkg.sv
// ----------------------------------------------------------------------------
// tdln_pkg
// shared types for the tree depth level normaliser: controller states and
// the command / status groups between controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package tdln_pkg;

  // width of the depth fields on the ports
  localparam int unsigned FIELD_W = 8;

  // controller states
  typedef enum logic [3:0] {
    S_LOAD,
    S_FIND_RD,
    S_FIND_EV,
    S_MIN_RD,
    S_MIN_EV,
    S_RUN_END,
    S_ADJ_RD,
    S_ADJ_WR,
    S_OUT_RD,
    S_OUT_EV
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_store;     // write incoming depth at the fill position
    logic load_drop;      // store full, flag the list as overflowed
    logic idx_clr;        // scan index back to zero
    logic idx_inc;        // scan index forward
    logic idx_from_first; // scan index to start of current run
    logic lvl_clr;        // level back to zero
    logic lvl_inc;        // next level
    logic run_start;      // open a run at the scan index
    logic min_upd;        // fold read depth into run minimum
    logic run_end;        // close run: capture end index and gap
    logic adj_wr;         // write back lowered depth
    logic out_load;       // load output register
    logic list_clr;       // clear fill count, overflow flag and deepest level
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic store_full;     // fill count at capacity
    logic idx_at_count;   // scan index past last stored node
    logic idx_at_stop;    // scan index at end of run
    logic lvl_at_deepest; // current level is the deepest level
    logic rd_deep;        // read depth at or above current level
    logic min_gt_lvl;     // run minimum above current level
    logic out_free;       // output register free for a new result
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/tdln_ctrl.sv
// ----------------------------------------------------------------------------
// tdln_ctrl
// sequencer: load phase, per-level run scan and lowering, result drain
// ----------------------------------------------------------------------------
`default_nettype none

module tdln_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_last_node,
  output logic                in_ready,
  input  wire tdln_pkg::sts_t sts,
  output tdln_pkg::cmd_t      cmd
);

  tdln_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdln_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      tdln_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (sts.store_full) begin
            cmd.load_drop = 1'b1;
          end else begin
            cmd.load_store = 1'b1;
          end
          if (in_last_node) begin
            cmd.idx_clr = 1'b1;
            cmd.lvl_clr = 1'b1;
            state_nxt   = tdln_pkg::S_FIND_RD;
          end
        end
      end
      // look for the start of a run at the current level
      tdln_pkg::S_FIND_RD: begin
        if (sts.idx_at_count) begin
          cmd.idx_clr = 1'b1;
          if (sts.lvl_at_deepest) begin
            state_nxt = tdln_pkg::S_OUT_RD;
          end else begin
            cmd.lvl_inc = 1'b1;
          end
        end else begin
          state_nxt = tdln_pkg::S_FIND_EV;
        end
      end
      tdln_pkg::S_FIND_EV: begin
        cmd.idx_inc = 1'b1;
        if (sts.rd_deep) begin
          cmd.run_start = 1'b1;
          state_nxt     = tdln_pkg::S_MIN_RD;
        end else begin
          state_nxt = tdln_pkg::S_FIND_RD;
        end
      end
      // extend run and track its minimum
      tdln_pkg::S_MIN_RD: begin
        if (sts.idx_at_count) begin
          cmd.run_end = 1'b1;
          state_nxt   = tdln_pkg::S_RUN_END;
        end else begin
          state_nxt = tdln_pkg::S_MIN_EV;
        end
      end
      tdln_pkg::S_MIN_EV: begin
        if (sts.rd_deep) begin
          cmd.min_upd = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt   = tdln_pkg::S_MIN_RD;
        end else begin
          cmd.run_end = 1'b1;
          state_nxt   = tdln_pkg::S_RUN_END;
        end
      end
      // lower the run only if its minimum sits above the level
      tdln_pkg::S_RUN_END: begin
        if (sts.min_gt_lvl) begin
          cmd.idx_from_first = 1'b1;
          state_nxt          = tdln_pkg::S_ADJ_RD;
        end else begin
          state_nxt = tdln_pkg::S_FIND_RD;
        end
      end
      tdln_pkg::S_ADJ_RD: begin
        if (sts.idx_at_stop) begin
          state_nxt = tdln_pkg::S_FIND_RD;
        end else begin
          state_nxt = tdln_pkg::S_ADJ_WR;
        end
      end
      tdln_pkg::S_ADJ_WR: begin
        cmd.adj_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = tdln_pkg::S_ADJ_RD;
      end
      // drain results in list order
      tdln_pkg::S_OUT_RD: begin
        if (sts.idx_at_count) begin
          cmd.list_clr = 1'b1;
          state_nxt    = tdln_pkg::S_LOAD;
        end else if (sts.out_free) begin
          state_nxt = tdln_pkg::S_OUT_EV;
        end
      end
      tdln_pkg::S_OUT_EV: begin
        cmd.out_load = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = tdln_pkg::S_OUT_RD;
      end
      default: begin
        state_nxt = tdln_pkg::S_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/tdln_dpath.sv
// ----------------------------------------------------------------------------
// tdln_dpath
// depth store, scan index, level and run registers, output register
// ----------------------------------------------------------------------------
`default_nettype none

module tdln_dpath #(
  parameter int unsigned MAX_NODES  = 64,
  parameter int unsigned DEPTH_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [tdln_pkg::FIELD_W-1:0]  in_node_depth,
  input  wire tdln_pkg::cmd_t                cmd,
  output tdln_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tdln_pkg::FIELD_W-1:0]       out_new_depth,
  output logic                               out_last_result,
  output logic                               out_overflowed
);

  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned DW = DEPTH_BITS;
  localparam int unsigned XW = (DW > tdln_pkg::FIELD_W) ? DW : tdln_pkg::FIELD_W;

  logic [DW-1:0] mem [MAX_NODES];

  logic [CW-1:0] count_r, idx_r, first_r, stop_r;
  logic          ovf_r;
  logic [DW-1:0] deepest_r, lvl_r, min_r, gap_r, rdata_r;
  logic          out_valid_r, out_last_r, out_ovf_r;
  logic [tdln_pkg::FIELD_W-1:0] out_depth_r;

  logic [XW-1:0] in_ext, rd_ext;
  logic [DW-1:0] in_d;
  logic [CW-1:0] idx_inc;

  // port width adaption
  assign in_ext  = XW'(in_node_depth);
  assign in_d    = in_ext[DW-1:0];
  assign rd_ext  = XW'(rdata_r);
  assign idx_inc = idx_r + CW'(1);

  // depth store, read address is always the scan index
  always_ff @(posedge clk) begin
    if (cmd.load_store) begin
      mem[count_r[AW-1:0]] <= in_d;
    end else if (cmd.adj_wr) begin
      mem[idx_r[AW-1:0]] <= rdata_r - gap_r;
    end
    rdata_r <= mem[idx_r[AW-1:0]];
  end

  // list bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ovf_r     <= 1'b0;
      deepest_r <= '0;
    end else if (cmd.list_clr) begin
      count_r   <= '0;
      ovf_r     <= 1'b0;
      deepest_r <= '0;
    end else begin
      if (cmd.load_store) begin
        count_r <= count_r + CW'(1);
        if (in_d > deepest_r) begin
          deepest_r <= in_d;
        end
      end
      if (cmd.load_drop) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // scan index, level and run registers
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_from_first) begin
      idx_r <= first_r;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_inc;
    end
    if (cmd.lvl_clr) begin
      lvl_r <= '0;
    end else if (cmd.lvl_inc) begin
      lvl_r <= lvl_r + DW'(1);
    end
    if (cmd.run_start) begin
      first_r <= idx_r;
      min_r   <= rdata_r;
    end else if (cmd.min_upd && (rdata_r < min_r)) begin
      min_r <= rdata_r;
    end
    if (cmd.run_end) begin
      stop_r <= idx_r;
      gap_r  <= min_r - lvl_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_depth_r <= rd_ext[tdln_pkg::FIELD_W-1:0];
      out_last_r  <= (idx_inc == count_r);
      out_ovf_r   <= ovf_r;
    end
  end

  // status to controller
  always_comb begin
    sts.store_full     = (count_r == CW'(MAX_NODES));
    sts.idx_at_count   = (idx_r == count_r);
    sts.idx_at_stop    = (idx_r == stop_r);
    sts.lvl_at_deepest = (lvl_r == deepest_r);
    sts.rd_deep        = (rdata_r >= lvl_r);
    sts.min_gt_lvl     = (min_r > lvl_r);
    sts.out_free       = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_new_depth   = out_depth_r;
  assign out_last_result = out_last_r;
  assign out_overflowed  = out_ovf_r;

endmodule

`default_nettype wire

>>> rtl/core/tree_depth_level_normalizer_core.sv
// load: one node a cycle, in_ready high until the last node is taken
// normalise, per level 0..deepest: 2 cycles per node scanned + 1, each run
//   2 more (3 if it ends before the last node), a lowered run 2 per node + 1
// drain: 2 cycles per result while out_ready is high, then 1 back to load
// first result 2*N + 5 cycles after the last node for a list of all-zero depths
// synchronous active-low reset empties the list; store contents are kept
// ----------------------------------------------------------------------------
// tree_depth_level_normalizer_core
// collects a list of node depths and removes empty depth levels per subtree
// ----------------------------------------------------------------------------
`default_nettype none

module tree_depth_level_normalizer_core #(
  parameter int unsigned MAX_NODES  = 64,
  parameter int unsigned DEPTH_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tdln_pkg::FIELD_W-1:0]  in_node_depth,
  input  wire logic                          in_last_node,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tdln_pkg::FIELD_W-1:0]       out_new_depth,
  output logic                               out_last_result,
  output logic                               out_overflowed
);

  tdln_pkg::cmd_t cmd;
  tdln_pkg::sts_t sts;

  // sequencer
  tdln_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_node (in_last_node),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // store and arithmetic
  tdln_dpath #(
    .MAX_NODES  (MAX_NODES),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_node_depth   (in_node_depth),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_depth   (out_new_depth),
    .out_last_result (out_last_result),
    .out_overflowed  (out_overflowed)
  );

endmodule

`default_nettype wire

>>> rtl/core/tdln_checker.sv
// ----------------------------------------------------------------------------
// tdln_checker
// port-level checks on the normaliser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tdln_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_last_node,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_new_depth,
  input wire logic       out_last_result,
  input wire logic       out_overflowed
);

  // input side closes only after the last node of a list is transferred
  a_close_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_last_node))
    else $error("input closed without a last-node transfer");

  // a new result never appears while nodes are being loaded
  a_no_result_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_ready)
    else $error("result raised during load phase");

  // while loading, only the final result of the previous list may wait
  a_pending_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> out_last_result)
    else $error("non-final result pending during load");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_new_depth)
      && $stable(out_last_result) && $stable(out_overflowed)))
    else $error("stalled result changed");

endmodule

bind tree_depth_level_normalizer_core tdln_checker u_tdln_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_node    (in_last_node),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_new_depth   (out_new_depth),
  .out_last_result (out_last_result),
  .out_overflowed  (out_overflowed)
);

`default_nettype wire

>>> tb/tb_tree_depth_level_normalizer_core.sv
// ----------------------------------------------------------------------------
// tb_tree_depth_level_normalizer_core
// self-checking bench for the depth level normaliser: node lists are sent
// over the input channel, a local model flattens the empty levels of each
// list, and every result transfer is compared with the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tree_depth_level_normalizer_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DW          = tdln_pkg::FIELD_W;
  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PRINT_CAP   = 30;

  typedef logic [DW-1:0] depth_list_t[$];

  typedef struct packed {
    logic [DW-1:0] new_depth;
    logic          is_last;
    logic          overflow;
  } norm_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [DW-1:0] in_node_depth = '0;
  logic          in_last_node = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [DW-1:0] out_new_depth;
  logic          out_last_result;
  logic          out_overflowed;

  // local copy of the block state
  logic [DW-1:0] held_depth [CAPACITY];
  int            held_count = 0;
  bit            spill_seen = 1'b0;
  int            deepest_seen = 0;

  norm_result_t  normalised_q[$];

  // idling controls
  bit            src_gaps    = 1'b1;
  bit            sink_stalls = 1'b1;
  int            hold_request = 0;

  // bookkeeping
  int unsigned   mismatches      = 0;
  int unsigned   cycle_count     = 0;
  int unsigned   nodes_sent      = 0;
  int unsigned   lists_sent      = 0;
  int unsigned   results_checked = 0;
  int unsigned   overflow_lists  = 0;

  tree_depth_level_normalizer_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_node_depth   (in_node_depth),
    .in_last_node    (in_last_node),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_depth   (out_new_depth),
    .out_last_result (out_last_result),
    .out_overflowed  (out_overflowed)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               normalised_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic log_mismatch(input string what);
    if (mismatches < PRINT_CAP)
      $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // fold one accepted node into the local state; on the last node flatten
  // the empty levels and queue one prediction per stored node
  task automatic absorb_node(input logic [DW-1:0] depth, input logic last);
    int           lvl;
    int           k;
    int           j;
    int           first;
    int           low;
    bit           in_run;
    norm_result_t res;
    if (held_count < CAPACITY) begin
      held_depth[held_count] = depth;
      held_count++;
      if (int'(depth) > deepest_seen)
        deepest_seen = int'(depth);
    end else begin
      spill_seen = 1'b1;
    end
    if (last) begin
      for (lvl = 0; lvl <= deepest_seen; lvl++) begin
        in_run = 1'b0;
        first  = 0;
        // one step past the end closes a run that reaches the last node
        for (k = 0; k <= held_count; k++) begin
          if (k < held_count && int'(held_depth[k]) >= lvl) begin
            if (!in_run) begin
              first  = k;
              in_run = 1'b1;
            end
          end else if (in_run) begin
            in_run = 1'b0;
            low = int'(held_depth[first]);
            for (j = first + 1; j < k; j++)
              if (int'(held_depth[j]) < low)
                low = int'(held_depth[j]);
            // pull the whole run down so its shallowest node sits at lvl
            if (low > lvl)
              for (j = first; j < k; j++)
                held_depth[j] = DW'(int'(held_depth[j]) - (low - lvl));
          end
        end
      end
      for (k = 0; k < held_count; k++) begin
        res.new_depth = held_depth[k];
        res.is_last   = (k == held_count - 1);
        res.overflow  = spill_seen;
        normalised_q.push_back(res);
      end
      if (spill_seen)
        overflow_lists++;
      held_count   = 0;
      spill_seen   = 1'b0;
      deepest_seen = 0;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    norm_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (normalised_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result depth %0d last %0b ovf %0b",
                               out_new_depth, out_last_result, out_overflowed));
      end else begin
        exp_res = normalised_q.pop_front();
        results_checked++;
        if (out_new_depth !== exp_res.new_depth)
          log_mismatch($sformatf("new_depth %0d, expected %0d",
                                 out_new_depth, exp_res.new_depth));
        if (out_last_result !== exp_res.is_last)
          log_mismatch($sformatf("last_result %0b, expected %0b",
                                 out_last_result, exp_res.is_last));
        if (out_overflowed !== exp_res.overflow)
          log_mismatch($sformatf("overflowed %0b, expected %0b",
                                 out_overflowed, exp_res.overflow));
      end
    end
  end

  // receiver: long hold when asked, else random stall bursts
  initial begin
    int hold_left;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        hold_left    = hold_request;
        hold_request = 0;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // one input transfer; valid stays high after the transfer unless a gap
  // follows, so back to back nodes never see valid dropped and raised
  task automatic push_node(input logic [DW-1:0] depth, input logic last);
    in_valid      <= 1'b1;
    in_node_depth <= depth;
    in_last_node  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_node(depth, last);
    nodes_sent++;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_list(input depth_list_t depths);
    for (int i = 0; i < depths.size(); i++)
      push_node(depths[i], i == depths.size() - 1);
    lists_sent++;
  endtask

  // stop offering and wait for every pending result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (normalised_q.size() != 0) @(posedge clk);
  endtask

  function automatic depth_list_t random_depths(input int count, input int ceiling);
    depth_list_t q;
    for (int i = 0; i < count; i++)
      q.push_back(DW'($urandom_range(0, ceiling)));
    return q;
  endfunction

  // lone nodes at both depth extremes
  task automatic test_single_nodes();
    depth_list_t q;
    q = '{8'd0};
    send_list(q);
    q = '{8'd255};
    send_list(q);
    drain_results();
  endtask

  // gaps below the first node, inside subtrees and a far outlier
  task automatic test_level_gaps();
    depth_list_t q;
    q = '{8'd2, 8'd5, 8'd5, 8'd9, 8'd1, 8'd200, 8'd200, 8'd0};
    send_list(q);
    drain_results();
  endtask

  // every depth bit set and cleared
  task automatic test_bit_patterns();
    depth_list_t q;
    q = '{8'h55, 8'hAA, 8'hFF, 8'h00, 8'h80};
    send_list(q);
    drain_results();
  endtask

  // nothing to remove
  task automatic test_already_normal();
    depth_list_t q;
    q = '{8'd0, 8'd1, 8'd2, 8'd2, 8'd1, 8'd0};
    send_list(q);
    drain_results();
  endtask

  // store exactly full, then one and several nodes past capacity
  task automatic test_capacity();
    send_list(random_depths(CAPACITY, 15));
    send_list(random_depths(CAPACITY + 1, 15));
    send_list(random_depths(CAPACITY + 7, 15));
    drain_results();
  endtask

  // mostly short shallow lists, now and then a few nodes of any depth
  task automatic test_random_lists();
    int unsigned target;
    target = nodes_sent + 200;
    while (nodes_sent < target) begin
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0)
        send_list(random_depths($urandom_range(1, 4), 255));
      else
        send_list(random_depths($urandom_range(1, 12), 15));
      if ($urandom_range(0, 5) == 0)
        drain_results();
    end
    drain_results();
  endtask

  // receiver holds off while the next list is offered, so input stalls
  task automatic test_output_hold();
    src_gaps     = 1'b0;
    sink_stalls  = 1'b1;
    hold_request = 600;
    send_list(random_depths(8, 7));
    send_list(random_depths(10, 7));
    drain_results();
  endtask

  // closing stretch with no idling on either side
  task automatic test_streaming();
    int unsigned target;
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    target = nodes_sent + 40;
    while (nodes_sent < target)
      send_list(random_depths($urandom_range(1, 10), 15));
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_nodes();
    test_level_gaps();
    test_bit_patterns();
    test_already_normal();
    test_capacity();
    test_random_lists();
    test_output_hold();
    test_streaming();

    // let any stray result show up
    repeat (200) @(posedge clk);

    $display("sent %0d nodes in %0d lists (%0d past capacity), checked %0d results",
             nodes_sent, lists_sent, overflow_lists, results_checked);
    $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
